// File: design/mtw_pkg.sv
`default_nettype none

package mtw_pkg;

    // command codes carried in the mode field
    typedef enum logic [2:0] {
        MODE_REGISTER = 3'd0,
        MODE_FEED     = 3'd1,
        MODE_TICK     = 3'd2,
        MODE_DISABLE  = 3'd3,
        MODE_ENABLE   = 3'd4
    } mode_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_WALK
    } state_t;

    // operation of the shared slot update unit
    typedef enum logic {
        OP_TICK,
        OP_RELOAD
    } upd_op_t;

    // input word
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] watcher_id;
        logic [7:0] timeout_value;
    } req_t;

    // result word
    typedef struct packed {
        logic kick_hardware;
        logic id_accepted;
    } rsp_t;

    // one slot entry as stored in the table
    typedef struct packed {
        logic [7:0] timeout;
        logic [7:0] countdown;
    } slot_t;

    // status from the update unit
    typedef struct packed {
        slot_t slot;
        logic  stall;
    } upd_res_t;

endpackage

`default_nettype wire

// File: design/mtw_slot_mem.sv
`default_nettype none

module mtw_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire logic [AW-1:0]  wr_addr,
    input  wire mtw_pkg::slot_t wr_data,
    input  wire logic [AW-1:0]  rd_addr,
    output mtw_pkg::slot_t      rd_data
);

    mtw_pkg::slot_t   mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    mtw_pkg::slot_t   rd_data_reg;
    logic             rd_valid_reg;

    // slot storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // per-slot written flags, a slot never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// File: design/mtw_slot_upd.sv
`default_nettype none

module mtw_slot_upd (
    input  wire mtw_pkg::upd_op_t op,
    input  wire mtw_pkg::slot_t   slot_in,
    output mtw_pkg::upd_res_t     res
);

    logic [7:0] dec;

    // saturating decrement of the countdown
    assign dec = (slot_in.countdown != 8'd0) ? slot_in.countdown - 8'd1 : 8'd0;

    always_comb
    begin
        res.slot  = slot_in;
        res.stall = 1'b0;
        case (op)
            mtw_pkg::OP_TICK:
            begin
                // inactive slots are left alone and never block the kick
                if (slot_in.timeout != 8'd0)
                begin
                    res.slot.countdown = dec;
                    res.stall          = (dec == 8'd0);
                end
            end
            mtw_pkg::OP_RELOAD:
            begin
                res.slot.countdown = slot_in.timeout;
            end
            default:
            begin
                res.slot = slot_in;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/multi_task_watchdog_supervisor_unit.sv
`default_nettype none

// Multi-task watchdog supervisor.
// Command channel: req is taken at a rising edge where start is high and
// busy is low. Each command gives exactly one response word on rsp, shown
// for one cycle with done high; the receiver cannot stall it.
// Register, disable, enable-while-enabled, tick-while-disabled, feed with a
// rejected id and unknown modes answer in the cycle after start (busy stays
// low). Feed of an accepted id reads the slot, writes it back in ST_FEED
// while busy, and answers after that. Tick while enabled, and enable while
// disabled, walk the whole slot table through the single update unit and
// the one-read, one-write slot memory: one slot per cycle, pipelined over
// the registered read; busy stays high until the last slot is written
// back, and the response follows.
// Reset: all slots read as inactive with zero countdown, supervision is on,
// the sequencer is idle and no response is pending. No clearing pass is
// run; per-slot written flags mask slots never written.

module multi_task_watchdog_supervisor_unit #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire mtw_pkg::req_t req,
    output logic               done,
    output mtw_pkg::rsp_t      rsp
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    mtw_pkg::state_t  state_reg, state_next;
    mtw_pkg::upd_op_t op_reg, op_next;
    logic             on_reg, on_next;
    logic [AW:0]      idx_reg, idx_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic             kick_reg, kick_next;
    logic             done_reg, done_next;
    mtw_pkg::rsp_t    rsp_reg, rsp_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    mtw_pkg::slot_t    wr_data;
    logic [AW-1:0]     rd_addr;
    mtw_pkg::slot_t    rd_data;
    mtw_pkg::upd_op_t  upd_op;
    mtw_pkg::upd_res_t upd_res;
    logic              id_ok;

    mtw_slot_mem #(
        .DEPTH (SLOT_COUNT),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mtw_slot_upd u_upd (
        .op      (upd_op),
        .slot_in (rd_data),
        .res     (upd_res)
    );

    assign id_ok = (req.watcher_id < 8'(SLOT_COUNT));
    assign busy  = (state_reg != mtw_pkg::ST_IDLE);
    assign done  = done_reg;
    assign rsp   = rsp_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtw_pkg::ST_IDLE;
            on_reg    <= 1'b1;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            on_reg    <= on_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        addr_reg <= addr_next;
        kick_reg <= kick_next;
        rsp_reg  <= rsp_next;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        on_next    = on_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        addr_next  = addr_reg;
        kick_next  = kick_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        wr_en      = 1'b0;
        wr_addr    = addr_reg;
        wr_data    = upd_res.slot;
        rd_addr    = idx_reg[AW-1:0];
        upd_op     = op_reg;

        case (state_reg)
            mtw_pkg::ST_IDLE:
            begin
                rd_addr   = req.watcher_id[AW-1:0];
                addr_next = req.watcher_id[AW-1:0];
                idx_next  = '0;
                pend_next = 1'b0;
                kick_next = 1'b1;
                if (start)
                begin
                    rsp_next.kick_hardware = 1'b0;
                    rsp_next.id_accepted   = 1'b1;
                    done_next              = 1'b1;
                    case (req.mode)
                        mtw_pkg::MODE_REGISTER:
                        begin
                            rsp_next.id_accepted = id_ok;
                            wr_en                = id_ok;
                            wr_addr              = req.watcher_id[AW-1:0];
                            wr_data.timeout      = req.timeout_value;
                            wr_data.countdown    = req.timeout_value;
                        end
                        mtw_pkg::MODE_FEED:
                        begin
                            if (id_ok)
                            begin
                                done_next  = 1'b0;
                                op_next    = mtw_pkg::OP_RELOAD;
                                state_next = mtw_pkg::ST_FEED;
                            end
                            else
                            begin
                                rsp_next.id_accepted = 1'b0;
                            end
                        end
                        mtw_pkg::MODE_TICK:
                        begin
                            if (on_reg)
                            begin
                                done_next  = 1'b0;
                                op_next    = mtw_pkg::OP_TICK;
                                state_next = mtw_pkg::ST_WALK;
                            end
                            else
                            begin
                                rsp_next.kick_hardware = 1'b1;
                            end
                        end
                        mtw_pkg::MODE_DISABLE:
                        begin
                            on_next = 1'b0;
                        end
                        mtw_pkg::MODE_ENABLE:
                        begin
                            if (!on_reg)
                            begin
                                done_next  = 1'b0;
                                op_next    = mtw_pkg::OP_RELOAD;
                                state_next = mtw_pkg::ST_WALK;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            mtw_pkg::ST_FEED:
            begin
                // slot read is back, write countdown from timeout
                upd_op                 = mtw_pkg::OP_RELOAD;
                wr_en                  = 1'b1;
                done_next              = 1'b1;
                rsp_next.kick_hardware = 1'b0;
                rsp_next.id_accepted   = 1'b1;
                state_next             = mtw_pkg::ST_IDLE;
            end

            mtw_pkg::ST_WALK:
            begin
                // write back the slot read last cycle
                if (pend_reg)
                begin
                    wr_en = 1'b1;
                    if (upd_res.stall)
                    begin
                        kick_next = 1'b0;
                    end
                end
                // issue the next slot read
                if (idx_reg < (AW+1)'(SLOT_COUNT))
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                    addr_next = idx_reg[AW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        done_next              = 1'b1;
                        rsp_next.kick_hardware = (op_reg == mtw_pkg::OP_TICK) && kick_reg;
                        rsp_next.id_accepted   = 1'b1;
                        if (op_reg == mtw_pkg::OP_RELOAD)
                        begin
                            on_next = 1'b1;
                        end
                        state_next = mtw_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = mtw_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // a response only follows an accepted command or a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("response without a command");

    // a kick is never paired with a rejected id
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.kick_hardware) |-> rsp.id_accepted)
        else $error("kick with rejected id");

    // feed write-back is entered from idle and goes straight back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mtw_pkg::ST_FEED) |=> (state_reg == mtw_pkg::ST_IDLE))
        else $error("feed state held too long");
`endif

endmodule

`default_nettype wire
